FILE: rtl/mes_pkg.sv
// Shared types, codes and datapath command set of the speed scheduler.
`timescale 1ns / 1ps
`default_nettype none

package mes_pkg;

  // Input action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_SLICE   = 2'd0;
  localparam logic [1:0] ST_UNSCHED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Fixed point: Q16.16 times, Q1.16 speed with one integer bit.
  localparam int FRAC_BITS  = 16;
  localparam int SPEED_BITS = 17;

  typedef struct packed {
    logic        action;
    logic [15:0] release_req;
    logic [15:0] deadline;
    logic [15:0] work;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slice_task;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic [16:0] slice_speed;
    logic        last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef enum logic [5:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_FULL,
    OP_RUN_INIT,
    OP_ROUND,
    OP_X_RD,
    OP_X_SKIP,
    OP_X_GET,
    OP_Y_RD,
    OP_Y_SKIP,
    OP_Y_GET,
    OP_Z_SKIP,
    OP_Z_GET,
    OP_K_INIT,
    OP_K_GET,
    OP_CHECK,
    OP_MUL,
    OP_MUL_CMP,
    OP_NZ_INIT,
    OP_NZ_GET,
    OP_DIV_SPD,
    OP_DIV,
    OP_SPEED,
    OP_PS_INIT,
    OP_PS_GET,
    OP_PICK,
    OP_DUR,
    OP_EF_INIT,
    OP_EF_GET,
    OP_NB_INIT,
    OP_NB_GET,
    OP_SEG,
    OP_EM_INIT,
    OP_EM_GET,
    OP_EMIT,
    OP_FAIL,
    OP_CLEAN
  } dp_op_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic in_action;
    logic full;
    logic any_left;
    logic x_end;
    logic x_skip;
    logic y_end;
    logic y_skip;
    logic y_bad;
    logic z_end;
    logic z_skip;
    logic k_end;
    logic chk_skip;
    logic bw_zero;
    logic over;
    logic mul_done;
    logic div_done;
    logic nz;
    logic sel_valid;
    logic sel_zero;
    logic req_zero;
    logic moved;
    logic sc_full;
    logic sc_zero;
    logic em_last;
  } dp_st_t;

endpackage

`default_nettype wire

FILE: rtl/mes_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mes_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mes_ctrl.sv
// Controller state machine that sequences the scheduler datapath.
`timescale 1ns / 1ps
`default_nettype none

module mes_ctrl
  import mes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire dp_st_t st,
  output dp_op_t      op,
  output logic        busy
);

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_FULL, S_RUN, S_ROUND,
    S_XSTEP, S_XGET, S_YSTEP, S_YGET, S_ZSTEP, S_ZGET,
    S_KSTEP, S_KGET, S_CHECK, S_MUL, S_MCMP,
    S_DECIDE, S_NZSTEP, S_NZGET, S_DIV1,
    S_PSINIT, S_PSSTEP, S_PSGET, S_PICK, S_DIV2, S_DUR, S_PLOOP,
    S_EFINIT, S_EFSTEP, S_EFGET, S_NBINIT, S_NBSTEP, S_NBGET, S_SEG,
    S_EMSTART, S_EMINIT, S_EMSTEP, S_EMGET, S_EMIT, S_FAIL, S_CLEAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  assign busy = busy_r;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_ACCEPT;
          if (st.in_action == ACT_RUN) state_nxt = S_RUN;
          else if (st.full)            state_nxt = S_FULL;
          else                         state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin op = OP_LOAD; state_nxt = S_IDLE; end
      S_FULL: begin op = OP_FULL; state_nxt = S_IDLE; end
      S_RUN: begin op = OP_RUN_INIT; state_nxt = S_ROUND; end
      S_ROUND: begin
        op = OP_ROUND;
        state_nxt = st.any_left ? S_XSTEP : S_EMSTART;
      end
      S_XSTEP: begin
        priority if (st.x_end) state_nxt = S_DECIDE;
        else if (st.x_skip) op = OP_X_SKIP;
        else begin op = OP_X_RD; state_nxt = S_XGET; end
      end
      S_XGET: begin op = OP_X_GET; state_nxt = S_YSTEP; end
      S_YSTEP: begin
        priority if (st.y_end) begin op = OP_X_SKIP; state_nxt = S_XSTEP; end
        else if (st.y_skip) op = OP_Y_SKIP;
        else begin op = OP_Y_RD; state_nxt = S_YGET; end
      end
      S_YGET: begin
        op = OP_Y_GET;
        state_nxt = st.y_bad ? S_YSTEP : S_ZSTEP;
      end
      S_ZSTEP: begin
        priority if (st.z_end) begin op = OP_K_INIT; state_nxt = S_KSTEP; end
        else if (st.z_skip) op = OP_Z_SKIP;
        else state_nxt = S_ZGET;
      end
      S_ZGET: begin op = OP_Z_GET; state_nxt = S_ZSTEP; end
      S_KSTEP: state_nxt = st.k_end ? S_CHECK : S_KGET;
      S_KGET: begin op = OP_K_GET; state_nxt = S_KSTEP; end
      S_CHECK: begin
        op = OP_CHECK;
        state_nxt = (st.chk_skip || st.bw_zero) ? S_YSTEP : S_MUL;
      end
      S_MUL: begin
        if (st.mul_done) state_nxt = S_MCMP;
        else op = OP_MUL;
      end
      S_MCMP: begin op = OP_MUL_CMP; state_nxt = S_YSTEP; end
      S_DECIDE: begin
        priority if (st.bw_zero) begin op = OP_NZ_INIT; state_nxt = S_NZSTEP; end
        else if (st.over) state_nxt = S_FAIL;
        else begin op = OP_DIV_SPD; state_nxt = S_DIV1; end
      end
      S_NZSTEP: begin
        priority if (st.z_end) state_nxt = st.nz ? S_FAIL : S_EMSTART;
        else if (st.z_skip) op = OP_Z_SKIP;
        else state_nxt = S_NZGET;
      end
      S_NZGET: begin op = OP_NZ_GET; state_nxt = S_NZSTEP; end
      S_DIV1: begin
        if (st.div_done) begin op = OP_SPEED; state_nxt = S_PSINIT; end
        else op = OP_DIV;
      end
      S_PSINIT: begin op = OP_PS_INIT; state_nxt = S_PSSTEP; end
      S_PSSTEP: begin
        priority if (st.z_end) state_nxt = st.sel_valid ? S_PICK : S_ROUND;
        else if (st.z_skip) op = OP_Z_SKIP;
        else state_nxt = S_PSGET;
      end
      S_PSGET: begin op = OP_PS_GET; state_nxt = S_PSSTEP; end
      S_PICK: begin
        op = OP_PICK;
        state_nxt = st.sel_zero ? S_PSINIT : S_DIV2;
      end
      S_DIV2: begin
        if (st.div_done) state_nxt = S_DUR;
        else op = OP_DIV;
      end
      S_DUR: begin op = OP_DUR; state_nxt = S_PLOOP; end
      S_PLOOP: state_nxt = st.req_zero ? S_PSINIT : S_EFINIT;
      S_EFINIT: begin op = OP_EF_INIT; state_nxt = S_EFSTEP; end
      S_EFSTEP: begin
        if (st.k_end) state_nxt = st.moved ? S_EFINIT : S_NBINIT;
        else state_nxt = S_EFGET;
      end
      S_EFGET: begin op = OP_EF_GET; state_nxt = S_EFSTEP; end
      S_NBINIT: begin op = OP_NB_INIT; state_nxt = S_NBSTEP; end
      S_NBSTEP: state_nxt = st.k_end ? S_SEG : S_NBGET;
      S_NBGET: begin op = OP_NB_GET; state_nxt = S_NBSTEP; end
      S_SEG: begin
        if (st.sc_full) state_nxt = S_FAIL;
        else begin op = OP_SEG; state_nxt = S_PLOOP; end
      end
      S_EMSTART: state_nxt = st.sc_zero ? S_CLEAN : S_EMINIT;
      S_EMINIT: begin op = OP_EM_INIT; state_nxt = S_EMSTEP; end
      S_EMSTEP: state_nxt = st.k_end ? S_EMIT : S_EMGET;
      S_EMGET: begin op = OP_EM_GET; state_nxt = S_EMSTEP; end
      S_EMIT: begin
        op = OP_EMIT;
        state_nxt = st.em_last ? S_CLEAN : S_EMINIT;
      end
      S_FAIL: begin op = OP_FAIL; state_nxt = S_CLEAN; end
      S_CLEAN: begin op = OP_CLEAN; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mes_dp.sv
// Scheduler datapath: task and slice stores, scan counters, serial multiply and divide.
`timescale 1ns / 1ps
`default_nettype none

module mes_dp
  import mes_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int MAX_SLICES = 32,
  parameter int TIME_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire dp_op_t op,
  input  wire in_t    in_item,
  output dp_st_t      st,
  output logic        out_valid,
  output out_t        out_res
);

  localparam int TB   = TIME_BITS;
  localparam int IW   = $clog2(MAX_TASKS);
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int SW   = $clog2(MAX_SLICES);
  localparam int SCW  = $clog2(MAX_SLICES + 1);
  localparam int FW   = TB + FRAC_BITS;
  localparam int TW   = FW + CW + 1;
  localparam int WW   = TB + CW;
  localparam int PW   = WW + FW;
  localparam int KW   = 3 * TB + IW;
  localparam int DIVW = WW + 33;
  localparam int MCW  = $clog2(WW + 1);
  localparam int DCW  = $clog2(FW + 1);

  typedef struct packed {
    logic [TB-1:0] r;
    logic [TB-1:0] d;
    logic [TB-1:0] w;
  } tsk_t;

  typedef struct packed {
    logic [IW-1:0]         tsk;
    logic [TW-1:0]         st;
    logic [TW-1:0]         en;
    logic [SPEED_BITS-1:0] spd;
  } slc_t;

  // Control state
  logic [CW-1:0]         count_r;
  logic [MAX_TASKS-1:0]  done_r;
  logic [SCW-1:0]        sc_r;
  logic [MAX_SLICES-1:0] emitted_r;
  logic                  out_valid_r;
  // Payload and loop registers
  in_t                   req_r;
  logic [CW-1:0]         ix_r, iy_r, iz_r;
  logic [SCW-1:0]        k_r, ne_r;
  logic [TB-1:0]         s_r, e_r, bs_r, be_r;
  logic [KW-1:0]         ykey_r, bkey_r, selkey_r;
  logic [WW-1:0]         w_r, bw_r, mp1_r, mp2_r;
  logic [FW-1:0]         busy_r, f_r, bf_r, quo_r, rq_r;
  logic [PW-1:0]         acc1_r, acc2_r, mc1_r, mc2_r;
  logic [MCW-1:0]        mcnt_r;
  logic [DIVW-1:0]       rem_r, dsh_r;
  logic [DCW-1:0]        dcnt_r;
  logic [SPEED_BITS-1:0] speed_r;
  logic                  nz_r, selv_r, moved_r;
  logic [IW-1:0]         sel_r;
  logic [TB-1:0]         sel_rel_r, sel_w_r;
  logic [TW-1:0]         t_r, nb_r;
  logic [SW-1:0]         em_k_r;
  slc_t                  em_d_r;
  out_t                  out_r;

  tsk_t          trd;
  slc_t          srd;
  logic          task_we, slc_we;
  logic [IW-1:0] task_raddr;
  slc_t          slc_wdata;

  // Combinational helpers
  logic [FW-1:0] len, f_cur;
  logic [TW-1:0] s_q, e_q, lo, hi, gap, seg;
  logic          better, ps_in, any_left;
  logic [KW-1:0] ps_key;

  assign task_we = (op == OP_LOAD);
  assign slc_we  = (op == OP_SEG);

  always_comb begin
    unique case (op)
      OP_X_RD: task_raddr = ix_r[IW-1:0];
      OP_Y_RD: task_raddr = iy_r[IW-1:0];
      default: task_raddr = iz_r[IW-1:0];
    endcase
  end

  mes_ram #(.W(3 * TB), .D(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (count_r[IW-1:0]),
    .wdata ({TB'(req_r.release_req), TB'(req_r.deadline), TB'(req_r.work)}),
    .raddr (task_raddr),
    .rdata (trd)
  );

  mes_ram #(.W(IW + 2 * TW + SPEED_BITS), .D(MAX_SLICES)) u_slice_ram (
    .clk   (clk),
    .we    (slc_we),
    .waddr (sc_r[SW-1:0]),
    .wdata (slc_wdata),
    .raddr (k_r[SW-1:0]),
    .rdata (srd)
  );

  always_comb begin
    s_q   = TW'({s_r, {FRAC_BITS{1'b0}}});
    e_q   = TW'({e_r, {FRAC_BITS{1'b0}}});
    len   = {e_r, {FRAC_BITS{1'b0}}} - {s_r, {FRAC_BITS{1'b0}}};
    f_cur = len - busy_r;
    lo    = (srd.st > s_q) ? srd.st : s_q;
    hi    = (srd.en < e_q) ? srd.en : e_q;
    gap   = nb_r - t_r;
    seg   = (TW'(rq_r) < gap) ? TW'(rq_r) : gap;
    slc_wdata = '{tsk: sel_r, st: t_r, en: t_r + seg, spd: speed_r};
    // Equal densities go to the earlier start, then to the lower end-task key.
    better = (acc1_r > acc2_r) ||
             ((acc1_r == acc2_r) &&
              ((s_r < bs_r) || ((s_r == bs_r) && (ykey_r < bkey_r))));
    ps_in  = (trd.r >= bs_r) && (trd.d <= be_r);
    ps_key = {trd, iz_r[IW-1:0]};
    any_left = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (!done_r[i] && (CW'(i) < count_r)) any_left = 1'b1;
    end
  end

  always_comb begin
    st.in_action = in_item.action;
    st.full      = (count_r == CW'(MAX_TASKS));
    st.any_left  = any_left;
    st.x_end     = (ix_r == count_r);
    st.x_skip    = done_r[ix_r[IW-1:0]];
    st.y_end     = (iy_r == count_r);
    st.y_skip    = done_r[iy_r[IW-1:0]];
    st.y_bad     = (trd.d <= s_r);
    st.z_end     = (iz_r == count_r);
    st.z_skip    = done_r[iz_r[IW-1:0]];
    st.k_end     = (k_r == sc_r);
    st.chk_skip  = (busy_r >= len) || (w_r == '0);
    st.bw_zero   = (bw_r == '0);
    st.over      = ({bw_r, {FRAC_BITS{1'b0}}} > (WW + FRAC_BITS)'(bf_r));
    st.mul_done  = (mcnt_r == '0);
    st.div_done  = (dcnt_r == '0);
    st.nz        = nz_r;
    st.sel_valid = selv_r;
    st.sel_zero  = (sel_w_r == '0);
    st.req_zero  = (rq_r == '0);
    st.moved     = moved_r;
    st.sc_full   = (sc_r == SCW'(MAX_SLICES));
    st.sc_zero   = (sc_r == '0);
    st.em_last   = ((ne_r + SCW'(1)) == sc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= '0;
      sc_r        <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (op)
        OP_NONE: ;
        OP_ACCEPT: req_r <= in_item;
        OP_LOAD: begin
          done_r[count_r[IW-1:0]] <= 1'b0;
          count_r <= count_r + CW'(1);
        end
        OP_FULL: begin
          out_valid_r <= 1'b1;
          out_r <= '{status: ST_FULL, last: 1'b1, default: '0};
        end
        OP_RUN_INIT: begin
          sc_r <= '0;
          ne_r <= '0;
        end
        OP_ROUND: begin
          bw_r <= '0;
          bf_r <= FW'(1);
          ix_r <= '0;
        end
        OP_X_RD: ;
        OP_X_SKIP: ix_r <= ix_r + CW'(1);
        OP_X_GET: begin
          s_r  <= trd.r;
          iy_r <= '0;
        end
        OP_Y_RD: ;
        OP_Y_SKIP: iy_r <= iy_r + CW'(1);
        OP_Y_GET: begin
          e_r    <= trd.d;
          ykey_r <= {trd, iy_r[IW-1:0]};
          w_r    <= '0;
          iz_r   <= '0;
          if (trd.d <= s_r) iy_r <= iy_r + CW'(1);
        end
        OP_Z_SKIP: iz_r <= iz_r + CW'(1);
        OP_Z_GET: begin
          if ((trd.r >= s_r) && (trd.d <= e_r)) w_r <= w_r + WW'(trd.w);
          iz_r <= iz_r + CW'(1);
        end
        OP_K_INIT: begin
          k_r    <= '0;
          busy_r <= '0;
        end
        OP_K_GET: begin
          if (hi > lo) busy_r <= busy_r + FW'(hi - lo);
          k_r <= k_r + SCW'(1);
        end
        OP_CHECK: begin
          iy_r <= iy_r + CW'(1);
          f_r  <= f_cur;
          if (!st.chk_skip) begin
            if (bw_r == '0) begin
              bw_r   <= w_r;
              bf_r   <= f_cur;
              bs_r   <= s_r;
              be_r   <= e_r;
              bkey_r <= ykey_r;
            end else begin
              acc1_r <= '0;
              acc2_r <= '0;
              mc1_r  <= PW'(bf_r);
              mp1_r  <= w_r;
              mc2_r  <= PW'(f_cur);
              mp2_r  <= bw_r;
              mcnt_r <= MCW'(WW);
            end
          end
        end
        OP_MUL: begin
          if (mp1_r[0]) acc1_r <= acc1_r + mc1_r;
          if (mp2_r[0]) acc2_r <= acc2_r + mc2_r;
          mc1_r  <= mc1_r << 1;
          mc2_r  <= mc2_r << 1;
          mp1_r  <= mp1_r >> 1;
          mp2_r  <= mp2_r >> 1;
          mcnt_r <= mcnt_r - MCW'(1);
        end
        OP_MUL_CMP: begin
          if (better) begin
            bw_r   <= w_r;
            bf_r   <= f_r;
            bs_r   <= s_r;
            be_r   <= e_r;
            bkey_r <= ykey_r;
          end
        end
        OP_NZ_INIT: begin
          iz_r <= '0;
          nz_r <= 1'b0;
        end
        OP_NZ_GET: begin
          if (trd.w != '0) nz_r <= 1'b1;
          iz_r <= iz_r + CW'(1);
        end
        OP_DIV_SPD: begin
          // Rounded-up quotient: numerator carries divisor minus one.
          rem_r  <= DIVW'({bw_r, 32'h0}) + DIVW'(bf_r) - DIVW'(1);
          dsh_r  <= DIVW'({bf_r, {FRAC_BITS{1'b0}}});
          quo_r  <= '0;
          dcnt_r <= DCW'(SPEED_BITS);
        end
        OP_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            quo_r <= {quo_r[FW-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[FW-2:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          dcnt_r <= dcnt_r - DCW'(1);
        end
        OP_SPEED: speed_r <= quo_r[SPEED_BITS-1:0];
        OP_PS_INIT: begin
          iz_r   <= '0;
          selv_r <= 1'b0;
        end
        OP_PS_GET: begin
          if (ps_in && (!selv_r || (ps_key < selkey_r))) begin
            selv_r    <= 1'b1;
            sel_r     <= iz_r[IW-1:0];
            selkey_r  <= ps_key;
            sel_rel_r <= trd.r;
            sel_w_r   <= trd.w;
          end
          iz_r <= iz_r + CW'(1);
        end
        OP_PICK: begin
          done_r[sel_r] <= 1'b1;
          rem_r  <= DIVW'({sel_w_r, 32'h0});
          dsh_r  <= DIVW'({speed_r, {(FW - 1){1'b0}}});
          quo_r  <= '0;
          dcnt_r <= DCW'(FW);
        end
        OP_DUR: begin
          rq_r <= quo_r;
          t_r  <= TW'({sel_rel_r, {FRAC_BITS{1'b0}}});
        end
        OP_EF_INIT: begin
          k_r     <= '0;
          moved_r <= 1'b0;
        end
        OP_EF_GET: begin
          if ((srd.st <= t_r) && (t_r < srd.en)) begin
            t_r     <= srd.en;
            moved_r <= 1'b1;
          end
          k_r <= k_r + SCW'(1);
        end
        OP_NB_INIT: begin
          k_r  <= '0;
          nb_r <= '1;
        end
        OP_NB_GET: begin
          if ((srd.st > t_r) && (srd.st < nb_r)) nb_r <= srd.st;
          k_r <= k_r + SCW'(1);
        end
        OP_SEG: begin
          sc_r <= sc_r + SCW'(1);
          t_r  <= t_r + seg;
          rq_r <= rq_r - FW'(seg);
        end
        OP_EM_INIT: begin
          k_r    <= '0;
          selv_r <= 1'b0;
        end
        OP_EM_GET: begin
          if (!emitted_r[k_r[SW-1:0]] && (!selv_r || (srd.st < em_d_r.st))) begin
            selv_r <= 1'b1;
            em_d_r <= srd;
            em_k_r <= k_r[SW-1:0];
          end
          k_r <= k_r + SCW'(1);
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
          out_r <= '{status:      ST_SLICE,
                     slice_task:  4'(em_d_r.tsk),
                     slice_start: 32'(em_d_r.st),
                     slice_end:   32'(em_d_r.en),
                     slice_speed: em_d_r.spd,
                     last:        st.em_last};
          emitted_r[em_k_r] <= 1'b1;
          ne_r <= ne_r + SCW'(1);
        end
        OP_FAIL: begin
          out_valid_r <= 1'b1;
          out_r <= '{status: ST_UNSCHED, last: 1'b1, default: '0};
        end
        OP_CLEAN: begin
          count_r   <= '0;
          done_r    <= '0;
          emitted_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

FILE: rtl/min_energy_speed_scheduler.sv
// Top level of the minimum-energy speed scheduler: controller, datapath and checks.
//
//   Channel | Ports                 | Handshake
//   --------+-----------------------+------------------------------------------
//   input   | start, busy, in_item  | request taken when start is high, busy low
//   result  | out_valid, out_res    | one-cycle strobe, always taken
//
// A load request is captured, then written into the task store. A refused load
// (store full) is captured, then the full state sets the registered result.
// How long a run request takes depends on the data: each critical-interval round
// runs the serial multiply for candidate intervals, and each placed task runs the
// divider and a scan of the slice store for every segment it is split into. The
// serial shift-add multiplier, the one-bit-per-cycle divider and the single read
// port of each store set that length. Each result waits for a rescan of the slice
// store for the earliest start not yet sent.
// Reset is synchronous and active low; it clears the task count, task and emitted
// flags, slice count, output strobe and controller state. The receiver cannot
// stall the result channel.
`timescale 1ns / 1ps
`default_nettype none

module min_energy_speed_scheduler
  import mes_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int MAX_SLICES = 32,
  parameter int TIME_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_res
);

  // The controller walks the critical-interval search, placement and the
  // start-ordered emission; the datapath holds every store and counter.
  dp_op_t op;
  dp_st_t st;

  mes_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  mes_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .MAX_SLICES (MAX_SLICES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_item   (in_item),
    .st        (st),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // An accepted request always leaves the controller working in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // Error results are always the only and final result of their request.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_SLICE) |-> out_res.last)
    else $error("error result without last");

  // The final result of a request is never followed directly by another.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |=> !out_valid)
    else $error("result right after final result");

endmodule

`default_nettype wire
